// ----- rtl/aud_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package aud_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_of_run;
    } t_out_item;

    localparam logic [0:0] CFG_CODEC  = 1'd0;
    localparam logic [0:0] CFG_VOLUME = 1'd1;
    localparam logic [15:0] VOL_UNITY = 16'd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCALE,
        ST_EMIT,
        ST_FINISH
    } t_state;

    function automatic logic [14:0] ima_step(input logic [6:0] si);
        logic [14:0] r;
        begin
            case (si)
                7'd0: r = 15'd7;      7'd1: r = 15'd8;      7'd2: r = 15'd9;
                7'd3: r = 15'd10;     7'd4: r = 15'd11;     7'd5: r = 15'd12;
                7'd6: r = 15'd13;     7'd7: r = 15'd14;     7'd8: r = 15'd16;
                7'd9: r = 15'd17;     7'd10: r = 15'd19;    7'd11: r = 15'd21;
                7'd12: r = 15'd23;    7'd13: r = 15'd25;    7'd14: r = 15'd28;
                7'd15: r = 15'd31;    7'd16: r = 15'd34;    7'd17: r = 15'd37;
                7'd18: r = 15'd41;    7'd19: r = 15'd45;    7'd20: r = 15'd50;
                7'd21: r = 15'd55;    7'd22: r = 15'd60;    7'd23: r = 15'd66;
                7'd24: r = 15'd73;    7'd25: r = 15'd80;    7'd26: r = 15'd88;
                7'd27: r = 15'd97;    7'd28: r = 15'd107;   7'd29: r = 15'd118;
                7'd30: r = 15'd130;   7'd31: r = 15'd143;   7'd32: r = 15'd157;
                7'd33: r = 15'd173;   7'd34: r = 15'd190;   7'd35: r = 15'd209;
                7'd36: r = 15'd230;   7'd37: r = 15'd253;   7'd38: r = 15'd279;
                7'd39: r = 15'd307;   7'd40: r = 15'd337;   7'd41: r = 15'd371;
                7'd42: r = 15'd408;   7'd43: r = 15'd449;   7'd44: r = 15'd494;
                7'd45: r = 15'd544;   7'd46: r = 15'd598;   7'd47: r = 15'd658;
                7'd48: r = 15'd724;   7'd49: r = 15'd796;   7'd50: r = 15'd876;
                7'd51: r = 15'd963;   7'd52: r = 15'd1060;  7'd53: r = 15'd1166;
                7'd54: r = 15'd1282;  7'd55: r = 15'd1411;  7'd56: r = 15'd1552;
                7'd57: r = 15'd1707;  7'd58: r = 15'd1878;  7'd59: r = 15'd2066;
                7'd60: r = 15'd2272;  7'd61: r = 15'd2499;  7'd62: r = 15'd2749;
                7'd63: r = 15'd3024;  7'd64: r = 15'd3327;  7'd65: r = 15'd3660;
                7'd66: r = 15'd4026;  7'd67: r = 15'd4428;  7'd68: r = 15'd4871;
                7'd69: r = 15'd5358;  7'd70: r = 15'd5894;  7'd71: r = 15'd6484;
                7'd72: r = 15'd7132;  7'd73: r = 15'd7845;  7'd74: r = 15'd8630;
                7'd75: r = 15'd9493;  7'd76: r = 15'd10442; 7'd77: r = 15'd11487;
                7'd78: r = 15'd12635; 7'd79: r = 15'd13899; 7'd80: r = 15'd15289;
                7'd81: r = 15'd16818; 7'd82: r = 15'd18500; 7'd83: r = 15'd20350;
                7'd84: r = 15'd22385; 7'd85: r = 15'd24623; 7'd86: r = 15'd27086;
                7'd87: r = 15'd29794;
                default: r = 15'd32767;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [4:0] delta4(input logic [3:0] c);
        logic signed [4:0] r;
        begin
            case (c)
                4'd0: r = -5'sd9;  4'd1: r = -5'sd8;  4'd2: r = -5'sd6;
                4'd3: r = -5'sd5;  4'd4: r = -5'sd4;  4'd5: r = -5'sd3;
                4'd6: r = -5'sd2;  4'd7: r = -5'sd1;  4'd8: r = 5'sd0;
                4'd9: r = 5'sd1;   4'd10: r = 5'sd2;  4'd11: r = 5'sd3;
                4'd12: r = 5'sd4;  4'd13: r = 5'sd5;  4'd14: r = 5'sd6;
                default: r = 5'sd8;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/aud_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
module aud_scale
    import aud_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic signed [15:0] i_value,
    input  wire logic        [15:0] i_volume,
    output logic signed [15:0]      o_scaled
);
    // Q15 gain, truncation toward zero; result registered
    logic        [15:0] vol_sat;
    logic signed [32:0] prod;
    logic signed [32:0] adj;
    logic signed [15:0] r_scaled;

    always_comb begin
        vol_sat = (i_volume > VOL_UNITY) ? VOL_UNITY : i_volume;
        prod = 33'(i_value) * $signed({17'd0, vol_sat});
        adj = prod[32] ? (prod + 33'sd32767) : prod;
    end

    always_ff @(posedge i_clk) begin
        r_scaled <= adj[30:15];
    end

    assign o_scaled = r_scaled;
endmodule
`default_nettype wire

// ----- rtl/aud_adpcm_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Steps: a header byte goes through decode and back to idle; a data byte goes
// through decode, scale and emit per sample (emit waits on output stall), then
// a last decode and finish. An IMA nibble that yields no sample adds a decode step.
// A byte yields up to 64 samples; the input stalls until the byte is finished
// and the unit is idle again, after the last one is loaded into the output register.
// Reset (synchronous, active low) clears stream state, codec 0, unity volume.
module aud_adpcm_stream_decoder_unit
    import aud_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    t_state r_state, n_state;
    logic        r_codec;
    logic [15:0] r_volume;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0] r_size, n_size;
    logic [15:0] r_bytes, n_bytes;
    logic [14:0] r_samp, n_samp;
    logic        r_raw, n_raw;
    logic [15:0] r_pred, n_pred;
    logic [6:0]  r_si, n_si;
    logic [1:0]  r_cmode, n_cmode;
    logic [6:0]  r_cleft, n_cleft;
    logic [7:0]  r_byte, n_byte;
    logic [6:0]  r_cnt, n_cnt;     // samples remaining for this byte
    logic [1:0]  r_pos, n_pos;     // sub-sample position in byte
    logic [1:0]  r_kind, n_kind;   // 0 ima, 1 repeat/single/raw, 2 delta2, 3 delta4
    logic        r_last, n_last;
    logic signed [15:0] r_val, n_val;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;
    logic signed [15:0] scaled;

    aud_scale u_scale (
        .i_clk(i_clk), .i_value(r_val), .i_volume(r_volume), .o_scaled(scaled)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec <= 1'b0;
            r_volume <= VOL_UNITY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_CODEC) r_codec <= i_cfg_data[0];
            else r_volume <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hdr_cnt <= '0; r_size <= '0; r_bytes <= '0; r_samp <= '0;
            r_raw <= 1'b0; r_pred <= '0; r_si <= '0; r_cmode <= '0;
            r_cleft <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hdr_cnt <= n_hdr_cnt; r_size <= n_size; r_bytes <= n_bytes;
            r_samp <= n_samp; r_raw <= n_raw; r_pred <= n_pred; r_si <= n_si;
            r_cmode <= n_cmode; r_cleft <= n_cleft; r_ov <= n_ov;
        end
        r_byte <= n_byte; r_cnt <= n_cnt; r_pos <= n_pos; r_kind <= n_kind;
        r_last <= n_last; r_val <= n_val; r_out <= n_out;
    end

    logic signed [15:0] cur8;
    logic [14:0] step;
    logic [16:0] diff;
    logic signed [17:0] psum;
    logic [3:0]  nib;
    logic signed [7:0] idx;
    logic signed [9:0] dsum;
    logic signed [4:0] dlt;
    logic [1:0]  c2;

    always_comb begin
        n_state = r_state;
        n_hdr_cnt = r_hdr_cnt; n_size = r_size; n_bytes = r_bytes;
        n_samp = r_samp; n_raw = r_raw; n_pred = r_pred; n_si = r_si;
        n_cmode = r_cmode; n_cleft = r_cleft;
        n_byte = r_byte; n_cnt = r_cnt; n_pos = r_pos; n_kind = r_kind;
        n_last = r_last; n_val = r_val; n_out = r_out;
        n_ov = r_ov && i_stall;
        cur8 = r_pred;
        if ($signed(r_pred) < 0) cur8 = 16'sd0;
        else if ($signed(r_pred) > 16'sd255) cur8 = 16'sd255;
        step = ima_step((r_si > 7'd88) ? 7'd88 : r_si);
        nib = r_pos[0] ? r_byte[7:4] : r_byte[3:0];
        diff = 17'(step >> 3);
        if (nib[0]) diff = diff + 17'(step >> 2);
        if (nib[1]) diff = diff + 17'(step >> 1);
        if (nib[2]) diff = diff + 17'(step);
        psum = nib[3] ? (18'($signed(r_pred)) - $signed({1'b0, diff}))
                      : (18'($signed(r_pred)) + $signed({1'b0, diff}));
        idx = $signed({1'b0, ((r_si > 7'd88) ? 7'd88 : r_si)});
        case (nib[2:0])
            3'd4: idx = idx + 8'sd2;
            3'd5: idx = idx + 8'sd4;
            3'd6: idx = idx + 8'sd6;
            3'd7: idx = idx + 8'sd8;
            default: idx = idx - 8'sd1;
        endcase
        c2 = r_byte[2*r_pos +: 2];
        case (c2)
            2'd0: dlt = -5'sd2;
            2'd1: dlt = -5'sd1;
            2'd2: dlt = 5'sd0;
            default: dlt = 5'sd1;
        endcase
        if (r_kind == 2'd3) dlt = delta4(nib);
        dsum = 10'(cur8) + 10'(dlt);

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_byte = i_item.data_byte;
                    n_pos = 2'd0;
                    n_cnt = 7'd0;
                    n_last = 1'b0;
                    if (i_item.stream_start) begin
                        n_hdr_cnt = '0; n_size = '0; n_bytes = '0; n_samp = '0;
                        n_raw = 1'b0; n_pred = r_codec ? 16'd128 : 16'd0;
                        n_si = '0; n_cmode = '0; n_cleft = '0;
                    end
                    n_state = ST_DECODE;
                    if (i_item.stream_start || r_hdr_cnt < 4'd8) begin
                        n_pos = 2'd3; // header marker
                    end else if (!r_codec) begin
                        n_kind = 2'd0;
                        n_cnt = 7'd2;
                    end else if (r_raw) begin
                        n_kind = 2'd1; n_cnt = 7'd1; n_val = '0;
                    end else if (r_cleft == 7'd0) begin
                        n_kind = 2'd1;
                        case (i_item.data_byte[7:6])
                            2'd3: n_cnt = {1'b0, i_item.data_byte[5:0]} + 7'd1;
                            2'd2: n_cnt = i_item.data_byte[5] ? 7'd1 : 7'd0;
                            default: n_cnt = 7'd0;
                        endcase
                    end else begin
                        case (r_cmode)
                            2'd0: begin n_kind = 2'd2; n_cnt = 7'd4; end
                            2'd1: begin n_kind = 2'd3; n_cnt = 7'd2; end
                            2'd2: begin n_kind = 2'd1; n_cnt = 7'd1; end
                            default: begin n_kind = 2'd1; n_cnt = 7'd0; end
                        endcase
                    end
                end
            end
            ST_DECODE: begin
                if (r_hdr_cnt < 4'd8 && r_cnt == 7'd0 && r_pos == 2'd3) begin
                    case (r_hdr_cnt)
                        4'd0: n_bytes = {8'd0, r_byte};
                        4'd1: n_bytes = {r_byte, r_bytes[7:0]};
                        4'd2: n_size = {8'd0, r_byte};
                        4'd3: begin
                            n_size = {r_byte, r_size[7:0]};
                            n_samp = n_size[15:1];
                            n_raw = (n_size == r_bytes);
                        end
                        default: ;
                    endcase
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                    if (r_hdr_cnt == 4'd7 && r_bytes == 16'd0) begin
                        n_cmode = '0; n_cleft = '0; n_hdr_cnt = '0;
                    end
                    n_state = ST_IDLE;
                end else if (!r_codec && r_cnt != 7'd0) begin
                    n_cnt = r_cnt - 7'd1;
                    if (r_samp != 15'd0) begin
                        if (psum < -18'sd32768) n_pred = 16'h8000;
                        else if (psum > 18'sd32767) n_pred = 16'h7FFF;
                        else n_pred = psum[15:0];
                        n_si = (idx < 0) ? 7'd0 : ((idx > 8'sd88) ? 7'd88 : idx[6:0]);
                        n_samp = r_samp - 15'd1;
                        n_val = $signed(n_pred);
                        n_last = (r_cnt == 7'd1) || (r_samp == 15'd1);
                        n_state = ST_SCALE;
                    end
                    n_pos = r_pos + 2'd1;
                end else if (r_codec && r_cnt != 7'd0) begin
                    n_cnt = r_cnt - 7'd1;
                    n_last = (r_cnt == 7'd1);
                    n_pos = r_pos + 2'd1;
                    if (r_kind == 2'd1) begin
                        if (r_raw || r_cleft != 7'd0) n_pred = {8'd0, r_byte};
                        else if (r_byte[7:6] == 2'd2)
                            dsum = 10'(cur8) + 10'($signed(r_byte[4:0]));
                        if (!r_raw && r_cleft == 7'd0 && r_byte[7:6] == 2'd2)
                            n_pred = (dsum < 0) ? 16'd0 :
                                     ((dsum > 10'sd255) ? 16'd255 : 16'(dsum));
                        else if (!r_raw && r_cleft == 7'd0) n_pred = cur8;
                    end else begin
                        n_pred = (dsum < 0) ? 16'd0 :
                                 ((dsum > 10'sd255) ? 16'd255 : 16'(dsum));
                    end
                    n_val = $signed({n_pred[7:0] ^ 8'h80, 8'd0});
                    n_state = ST_SCALE;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCALE: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_ov || !i_stall) begin
                    n_out.sample = scaled;
                    n_out.last_of_run = r_last;
                    n_ov = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_FINISH: begin
                if (r_codec) begin
                    if (r_raw) begin
                    end else if (r_cleft == 7'd0) begin
                        if (!(r_byte[7:6] == 2'd3 || (r_byte[7:6] == 2'd2 && r_byte[5])))
                        begin
                            n_cmode = r_byte[7:6];
                            n_cleft = {1'b0, r_byte[5:0]} + 7'd1;
                        end
                        n_pred = cur8;
                    end else begin
                        n_cleft = r_cleft - 7'd1;
                        if (r_cmode == 2'd3) n_pred = cur8;
                    end
                end
                n_bytes = r_bytes - 16'd1;
                if (n_bytes == 16'd0) begin
                    n_hdr_cnt = '0; n_cmode = '0; n_cleft = '0;
                end
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accept while busy");
    a_si_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_si <= 7'd88)) else $error("step index out of range");
    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_cnt <= 4'd8)) else $error("header count out of range");
    a_emit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCALE) |=> (r_state == ST_EMIT)) else $error("scale slot");
`endif
endmodule
`default_nettype wire
